[sv/per_client_in_order_ack_receiver_defines.svh]
// Assertion macros shared by the receiver RTL.
`ifndef PER_CLIENT_IN_ORDER_ACK_RECEIVER_DEFINES_SVH
`define PER_CLIENT_IN_ORDER_ACK_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PCOAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCOAR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pcoar_pkg.sv]
// Types and constants of the per-client in-order ACK receiver.
`default_nettype none

package pcoar_pkg;

  // Width and reset value of the client limit register
  localparam int unsigned LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;

  // Field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned ENTRY_W   = 5;

  // Result codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ACCEPTED     = 2'd0,
    OUT_OUT_OF_ORDER = 2'd1,
    OUT_TABLE_FULL   = 2'd2
  } outcome_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_WRITE = 3'b100
  } state_t;

endpackage

`default_nettype wire

[sv/per_client_in_order_ack_receiver.sv]
// Go-Back-N receiver top level: sender table, expected-sequence memory, ACK result.
`default_nettype none

// A packet header passes through a match state and a write state. In the match state
// the sender key is compared against every filled table entry in parallel and that
// entry's expected sequence is read into a register from the sequence memory. In the
// write state, once the result side is free, the sequence is checked, the memory is
// written back, the result register is loaded and the next header can be taken; a
// stalled result holds the block in its write state. Table entries need no clearing
// after reset: only entries below the fill count are matched. client_limit is written
// through cfg_valid/cfg_data and is always ready; write it only while the block is idle.

`include "per_client_in_order_ack_receiver_defines.svh"

module per_client_in_order_ack_receiver
  import pcoar_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIMIT_W-1:0]   cfg_data,
  // packet header in
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ADDR_W-1:0]    source_address,
  input  wire logic [PORT_W-1:0]    source_port,
  input  wire logic [SEQ_W-1:0]     sequence_number,
  // result out
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      send_ack,
  output logic [SEQ_W-1:0]          ack_number,
  output logic [OUTCOME_W-1:0]      outcome,
  output logic [ENTRY_W-1:0]        entry_index,
  output logic                      is_new_client
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (UW > LIMIT_W) ? UW : LIMIT_W;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTRIES);
  localparam logic [UW-1:0] MAX_UW = UW'(MAX_ENTRIES);

  state_t state, state_next;

  logic [LIMIT_W-1:0] client_limit;
  logic [UW-1:0]      used;

  // sender keys, one comparator per entry
  logic [ADDR_W-1:0] key_addr [MAX_ENTRIES];
  logic [PORT_W-1:0] key_port [MAX_ENTRIES];

  // expected sequence per entry
  logic [SEQ_W-1:0]  seq_mem  [MAX_ENTRIES];
  logic [SEQ_W-1:0]  seq_rd;

  // held header word
  logic [ADDR_W-1:0] hdr_addr;
  logic [PORT_W-1:0] hdr_port;
  logic [SEQ_W-1:0]  hdr_seq;

  // match results carried into the write cycle
  logic          m_hit;
  logic [IW-1:0] m_idx;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic                   hit_any;
  logic [IW-1:0]          hit_idx;

  logic                   in_accept;
  logic                   fire;
  logic [CW-1:0]          limit_cw;
  logic [CW-1:0]          lim_eff;
  logic                   full;
  logic                   create;
  logic [IW-1:0]          idx_w;
  logic [SEQ_W-1:0]       expected;
  logic                   in_order;
  logic [IW+ENTRY_W-1:0]  idx_ext;

  assign cfg_ready = 1'b1;

  // handshakes
  assign fire      = (state == S_WRITE) && (!out_valid || !out_stall);
  assign in_stall  = !((state == S_IDLE) || fire);
  assign in_accept = in_valid && !in_stall;

  // parallel key compare over the filled entries
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = (UW'(i) < used) && (key_addr[i] == hdr_addr) &&
                   (key_port[i] == hdr_port);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
    hit_any = |hit_vec;
  end

  // table full, new entry and sequence check
  always_comb begin
    limit_cw = CW'(client_limit);
    lim_eff  = (limit_cw > MAX_CW) ? MAX_CW : limit_cw;
    full     = !m_hit && (CW'(used) >= lim_eff);
    create   = !m_hit && !full;
    idx_w    = m_hit ? m_idx : used[IW-1:0];
    expected = create ? '0 : seq_rd;
    in_order = !full && (expected == hdr_seq);
    idx_ext  = {{ENTRY_W{1'b0}}, idx_w};
  end

  // sequencer
  always_comb begin
    case (state)
      S_IDLE:  state_next = in_accept ? S_MATCH : S_IDLE;
      S_MATCH: state_next = S_WRITE;
      S_WRITE: state_next = fire ? (in_accept ? S_MATCH : S_IDLE) : S_WRITE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      client_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      client_limit <= cfg_data;
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hdr_addr <= source_address;
      hdr_port <= source_port;
      hdr_seq  <= sequence_number;
    end
  end

  // match registers
  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      m_hit <= hit_any;
      m_idx <= hit_idx;
    end
  end

  // sequence memory: read in the match cycle, written back in the write cycle
  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      seq_rd <= seq_mem[hit_idx];
    end
    if (fire && (create || in_order)) begin
      seq_mem[idx_w] <= in_order ? hdr_seq + 1'b1 : '0;
    end
  end

  // new sender keys
  always_ff @(posedge clk) begin
    if (fire && create) begin
      key_addr[idx_w] <= hdr_addr;
      key_port[idx_w] <= hdr_port;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (fire && create) begin
      used <= used + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      send_ack      <= in_order;
      ack_number    <= in_order ? hdr_seq : '0;
      is_new_client <= create;
      entry_index   <= full ? '0 : idx_ext[ENTRY_W-1:0];
      if (full) begin
        outcome <= OUT_TABLE_FULL;
      end else if (in_order) begin
        outcome <= OUT_ACCEPTED;
      end else begin
        outcome <= OUT_OUT_OF_ORDER;
      end
    end
  end

  // checks
  `PCOAR_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used <= MAX_UW,
    "fill count beyond table size")
  `PCOAR_ASSERT_IMP(a_unique_key, clk, rst, state == S_MATCH, $onehot0(hit_vec),
    "sender key matches more than one entry")
  `PCOAR_ASSERT_IMP(a_full_result, clk, rst, out_valid && (outcome == OUT_TABLE_FULL),
    !send_ack && !is_new_client && (entry_index == '0), "table full result not cleared")
  `PCOAR_ASSERT_IMP(a_ack_outcome, clk, rst, out_valid && send_ack,
    outcome == OUT_ACCEPTED, "ACK raised on a dropped packet")
  `PCOAR_ASSERT_NXT(a_create_count, clk, rst, fire && create,
    used == $past(used) + 1'b1, "new entry did not advance fill count")

endmodule

`default_nettype wire
